[src/sfc_pkg.sv]
// ----------------------------------------------------------------------------
// sfc_pkg: shared types and constants for the sector framer
// Register map, reset values, CRC-16 byte update and the records passed
// between the front end, the job queue and the sector emitter.
// ----------------------------------------------------------------------------
package sfc_pkg;

  localparam int SECTOR_BYTES_DEFAULT = 512;
  localparam int MAX_WORDS            = 64;
  localparam int FRAME_BYTES          = 8;

  localparam logic [15:0] HEADER_RESET = 16'hFB3B;
  localparam logic [15:0] FOOTER_RESET = 16'h5F86;
  localparam logic [15:0] SEED_RESET   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY     = 16'h8005;

  localparam int          ADDR_BITS   = 4;
  localparam logic [3:0]  ADDR_HEADER = 4'h0;
  localparam logic [3:0]  ADDR_FOOTER = 4'h4;
  localparam logic [3:0]  ADDR_SEED   = 4'h8;

  typedef struct packed {
    logic [15:0] header;
    logic [15:0] footer;
    logic [15:0] seed;
  } cfg_t;

  // One finished sector waiting for the emitter
  typedef struct packed {
    logic [15:0] crc;
    logic [15:0] stime;
  } job_t;

  // MSb-first, unreflected CRC-16 over one byte
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

[src/sfc_ram.sv]
// ----------------------------------------------------------------------------
// sfc_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 504
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/sfc_job_fifo.sv]
// ----------------------------------------------------------------------------
// sfc_job_fifo: two-entry queue of finished sectors
// Decouples the byte front end from the sector emitter.
// ----------------------------------------------------------------------------
module sfc_job_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  sfc_pkg::job_t push_data,
  output logic          full,
  input  logic          pop,
  output sfc_pkg::job_t head,
  output logic          empty
);

  sfc_pkg::job_t entries [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;

  logic do_push;
  logic do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

[src/sfc_front.sv]
// ----------------------------------------------------------------------------
// sfc_front: byte intake and running CRC
// Writes bytes into the payload store, tracks fill, CRC and timestamp, and
// queues a sector job when a byte lands on a full payload.
// ----------------------------------------------------------------------------
module sfc_front #(
  parameter int SECTOR_BYTES = sfc_pkg::SECTOR_BYTES_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic [7:0]            data_byte,
  input  logic [15:0]           second_count,
  input  logic [15:0]           crc_seed,
  output logic                  job_push,
  output sfc_pkg::job_t         job_data,
  input  logic                  job_full,
  input  logic                  back_done,
  output logic                  ram_we,
  output logic [$clog2(SECTOR_BYTES-sfc_pkg::FRAME_BYTES)-1:0] ram_waddr,
  output logic [7:0]            ram_wdata
);

  localparam int PAYLOAD = SECTOR_BYTES - sfc_pkg::FRAME_BYTES;
  localparam int FW      = $clog2(PAYLOAD + 1);
  localparam int AW      = $clog2(PAYLOAD);

  logic [FW-1:0] fill;
  logic [15:0]   crc;
  logic [15:0]   stime;
  logic          pend;
  logic [7:0]    pend_byte;
  logic [15:0]   pend_secs;

  logic accept;
  logic is_full;
  logic reopen;

  assign full     = pend || job_full;
  assign accept   = push && !full;
  assign is_full  = (fill == FW'(PAYLOAD));
  assign reopen   = pend && back_done;

  assign job_push       = accept && is_full;
  assign job_data.crc   = crc;
  assign job_data.stime = stime;

  // the parked byte goes to position zero once the emitter has read the store
  assign ram_we    = (accept && !is_full) || reopen;
  assign ram_waddr = reopen ? '0 : AW'(fill);
  assign ram_wdata = reopen ? pend_byte : data_byte;

  always_ff @(posedge clk) begin
    if (accept && is_full) begin
      pend_byte <= data_byte;
      pend_secs <= second_count;
    end
    if (rst) begin
      fill  <= '0;
      crc   <= sfc_pkg::SEED_RESET;
      stime <= '0;
      pend  <= 1'b0;
    end else if (reopen) begin
      fill  <= FW'(1);
      crc   <= sfc_pkg::crc_byte(crc_seed, pend_byte);
      stime <= pend_secs;
      pend  <= 1'b0;
    end else if (accept) begin
      if (is_full) begin
        pend <= 1'b1;
      end else begin
        if (fill == '0) begin
          stime <= second_count;
        end
        crc  <= sfc_pkg::crc_byte(crc, data_byte);
        fill <= fill + FW'(1);
      end
    end
  end

endmodule

[src/sfc_back.sv]
// ----------------------------------------------------------------------------
// sfc_back: sector emitter
// Walks the sector byte by byte, reads payload from the store, packs
// 64-bit little-endian words and holds them in an output register.
// ----------------------------------------------------------------------------
module sfc_back #(
  parameter int SECTOR_BYTES = sfc_pkg::SECTOR_BYTES_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  sfc_pkg::cfg_t         cfg,
  input  logic                  job_empty,
  input  sfc_pkg::job_t         job_head,
  output logic                  job_pop,
  output logic                  done,
  output logic [$clog2(SECTOR_BYTES-sfc_pkg::FRAME_BYTES)-1:0] ram_raddr,
  input  logic [7:0]            ram_rdata,
  output logic                  empty,
  input  logic                  pop,
  output logic [63:0]           sector_word,
  output logic [5:0]            word_index,
  output logic                  last_word
);

  localparam int PAYLOAD   = SECTOR_BYTES - sfc_pkg::FRAME_BYTES;
  localparam int AW        = $clog2(PAYLOAD);
  localparam int WORDS_RAW = (SECTOR_BYTES + 7) / 8;
  localparam int WORDS     = (WORDS_RAW > sfc_pkg::MAX_WORDS) ? sfc_pkg::MAX_WORDS
                                                              : WORDS_RAW;
  localparam int TOTAL     = WORDS * 8;
  localparam int PW        = $clog2(TOTAL);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t        state;
  sfc_pkg::job_t job;
  logic [PW-1:0] pos;

  logic          s1_valid;
  logic [2:0]    s1_lane;
  logic          s1_ram;
  logic [7:0]    s1_fixed;
  logic [5:0]    s1_index;
  logic          s1_last;

  logic [7:0][7:0] asm_word;
  logic            asm_full;
  logic [5:0]      asm_index;
  logic            asm_last;

  logic          out_valid;
  logic [63:0]   out_word;
  logic [5:0]    out_index;
  logic          out_last;

  logic          issue;
  logic          from_ram;
  logic [7:0]    fixed_byte;
  logic          move;
  logic [7:0]    land_byte;

  // classify the current sector position
  always_comb begin
    int p;
    p          = int'(pos);
    from_ram   = 1'b0;
    fixed_byte = 8'h00;
    priority if (p >= SECTOR_BYTES) begin
      fixed_byte = 8'h00;
    end else if (p == 0) begin
      fixed_byte = cfg.header[7:0];
    end else if (p == 1) begin
      fixed_byte = cfg.header[15:8];
    end else if (p == 2) begin
      fixed_byte = job.stime[7:0];
    end else if (p == 3) begin
      fixed_byte = job.stime[15:8];
    end else if (p == SECTOR_BYTES - 4) begin
      fixed_byte = job.crc[7:0];
    end else if (p == SECTOR_BYTES - 3) begin
      fixed_byte = job.crc[15:8];
    end else if (p == SECTOR_BYTES - 2) begin
      fixed_byte = cfg.footer[7:0];
    end else if (p == SECTOR_BYTES - 1) begin
      fixed_byte = cfg.footer[15:8];
    end else begin
      from_ram = 1'b1;
    end
  end

  // hold issue while a finished word waits or a word's top byte is in flight
  assign issue     = (state == ST_RUN) && !asm_full && !(s1_valid && (s1_lane == 3'd7));
  assign done      = issue && (pos == PW'(TOTAL - 1));
  assign job_pop   = (state == ST_IDLE) && !job_empty;
  assign ram_raddr = AW'(pos - PW'(4));
  assign land_byte = s1_ram ? ram_rdata : s1_fixed;
  assign move      = asm_full && (!out_valid || pop);

  assign empty       = !out_valid;
  assign sector_word = out_word;
  assign word_index  = out_index;
  assign last_word   = out_last;

  always_ff @(posedge clk) begin
    if (job_pop) begin
      job <= job_head;
    end
    if (issue) begin
      s1_lane  <= pos[2:0];
      s1_ram   <= from_ram;
      s1_fixed <= fixed_byte;
      s1_index <= 6'(pos >> 3);
      s1_last  <= (pos == PW'(TOTAL - 1));
    end
    if (s1_valid) begin
      asm_word[s1_lane] <= land_byte;
      if (s1_lane == 3'd7) begin
        asm_index <= s1_index;
        asm_last  <= s1_last;
      end
    end
    if (move) begin
      out_word  <= asm_word;
      out_index <= asm_index;
      out_last  <= asm_last;
    end

    if (rst) begin
      state     <= ST_IDLE;
      pos       <= '0;
      s1_valid  <= 1'b0;
      asm_full  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid <= issue;
      unique case (state)
        ST_IDLE: begin
          if (job_pop) begin
            pos   <= '0;
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (issue) begin
            pos <= pos + PW'(1);
            if (done) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (s1_valid && (s1_lane == 3'd7)) begin
        asm_full <= 1'b1;
      end else if (move) begin
        asm_full <= 1'b0;
      end
      if (move) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[src/sector_framer_crc16.sv]
// ----------------------------------------------------------------------------
// sector_framer_crc16: CRC-16 framed sector packer
// Packs a byte stream into fixed-size sectors and emits each as 64-bit words.
// ----------------------------------------------------------------------------
// Bytes are pushed one per cycle into a payload store of SECTOR_BYTES-8
// entries while a running CRC-16 (poly 0x8005, MSb first, no final xor,
// seeded with 0xFFFF after reset, later from the seed register) is kept over
// them. The byte pushed after the payload is full closes the sector: the
// block emits up to 64 little-endian words (header, timestamp, payload, CRC,
// footer; a short last word is zero padded) and then opens the next sector
// with that byte. Intake runs at one byte per cycle; the closing byte raises
// full for the drain, in which the emitter walks the sector through the
// single byte read port of the payload store one byte a cycle, pausing after
// each word. Words are held in an output register; a slow consumer stalls
// the emitter and so keeps full high longer, since the next sector opens
// only once the drain ends. end_of_record is accepted but does not change
// framing. Write the configuration registers only while the block is idle.
// ----------------------------------------------------------------------------
module sector_framer_crc16 #(
  parameter int SECTOR_BYTES = sfc_pkg::SECTOR_BYTES_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  // byte intake
  input  logic                          push,
  output logic                          full,
  input  logic [7:0]                    data_byte,
  input  logic [15:0]                   second_count,
  input  logic                          end_of_record,
  // sector words
  output logic                          empty,
  input  logic                          pop,
  output logic [63:0]                   sector_word,
  output logic [5:0]                    word_index,
  output logic                          last_word,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sfc_pkg::ADDR_BITS-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int AW = $clog2(SECTOR_BYTES - sfc_pkg::FRAME_BYTES);

  sfc_pkg::cfg_t cfg;
  logic          cfg_write;

  sfc_pkg::job_t job_in;
  sfc_pkg::job_t job_head;
  logic          job_push;
  logic          job_pop;
  logic          job_full;
  logic          job_empty;
  logic          back_done;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  // Register file: header at 0x0, footer at 0x4, seed at 0x8; other
  // addresses write nothing and read zero.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header <= sfc_pkg::HEADER_RESET;
      cfg.footer <= sfc_pkg::FOOTER_RESET;
      cfg.seed   <= sfc_pkg::SEED_RESET;
    end else if (cfg_write) begin
      unique case (paddr)
        sfc_pkg::ADDR_HEADER: cfg.header <= pwdata[15:0];
        sfc_pkg::ADDR_FOOTER: cfg.footer <= pwdata[15:0];
        sfc_pkg::ADDR_SEED:   cfg.seed   <= pwdata[15:0];
        default:              cfg        <= cfg;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      sfc_pkg::ADDR_HEADER: prdata = {16'h0000, cfg.header};
      sfc_pkg::ADDR_FOOTER: prdata = {16'h0000, cfg.footer};
      sfc_pkg::ADDR_SEED:   prdata = {16'h0000, cfg.seed};
      default:              prdata = 32'h0000_0000;
    endcase
  end

  // Front end: takes bytes, updates CRC, parks the closing byte
  sfc_front #(
    .SECTOR_BYTES (SECTOR_BYTES)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .data_byte    (data_byte),
    .second_count (second_count),
    .crc_seed     (cfg.seed),
    .job_push     (job_push),
    .job_data     (job_in),
    .job_full     (job_full),
    .back_done    (back_done),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata)
  );

  // Finished sectors wait here until the emitter is free
  sfc_job_fifo u_jobs (
    .clk       (clk),
    .rst       (rst),
    .push      (job_push),
    .push_data (job_in),
    .full      (job_full),
    .pop       (job_pop),
    .head      (job_head),
    .empty     (job_empty)
  );

  // Payload store: written by the front end, read by the emitter
  sfc_ram #(
    .WIDTH (8),
    .DEPTH (SECTOR_BYTES - sfc_pkg::FRAME_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Emitter: walks the sector and packs words for the consumer
  sfc_back #(
    .SECTOR_BYTES (SECTOR_BYTES)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .job_empty   (job_empty),
    .job_head    (job_head),
    .job_pop     (job_pop),
    .done        (back_done),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata),
    .empty       (empty),
    .pop         (pop),
    .sector_word (sector_word),
    .word_index  (word_index),
    .last_word   (last_word)
  );

endmodule

[tb/sv/sector_framer_crc16_tb.sv]
// ----------------------------------------------------------------------------
// sector_framer_crc16_tb: self-checking bench for the CRC-16 sector framer
// Streams random bytes into the framer, computes every emitted sector word
// on the side (header, timestamp, payload, CRC-16/0x8005, footer) and checks
// each popped word field by field. Register writes go through the APB port
// between sectors, or between bytes while no sector is draining.
// ----------------------------------------------------------------------------
module sector_framer_crc16_tb;

  localparam int SECTOR_BYTES   = sfc_pkg::SECTOR_BYTES_DEFAULT;
  localparam int PAYLOAD_BYTES  = SECTOR_BYTES - sfc_pkg::FRAME_BYTES;
  // The drain walks the store one byte a cycle, pausing after each word; allow for a word still in flight
  localparam int DRAIN_GUARD    = 32;
  // Cycles with no word moving on either side before the run is declared hung
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct {
    logic [63:0] word;
    logic [5:0]  idx;
    logic        last;
  } word_due_t;

  typedef enum {POP_ALWAYS, POP_COIN, POP_PATTERN, POP_LONG} pop_mode_e;

  logic                          clk           = 1'b0;
  logic                          rst           = 1'b1;
  logic                          push          = 1'b0;
  logic                          full;
  logic [7:0]                    data_byte     = 8'h00;
  logic [15:0]                   second_count  = 16'h0000;
  logic                          end_of_record = 1'b0;
  logic                          empty;
  logic                          pop           = 1'b0;
  logic [63:0]                   sector_word;
  logic [5:0]                    word_index;
  logic                          last_word;
  logic                          psel          = 1'b0;
  logic                          penable       = 1'b0;
  logic                          pwrite        = 1'b0;
  logic [sfc_pkg::ADDR_BITS-1:0] paddr         = '0;
  logic [31:0]                   pwdata        = '0;
  logic [31:0]                   prdata;
  logic                          pready;

  // Side copy of the framer: configuration, payload and running CRC
  logic [15:0] cfg_header = sfc_pkg::HEADER_RESET;
  logic [15:0] cfg_footer = sfc_pkg::FOOTER_RESET;
  logic [15:0] cfg_seed   = sfc_pkg::SEED_RESET;
  logic [7:0]  payload_copy [PAYLOAD_BYTES];
  int          bytes_filled = 0;
  logic [15:0] crc_acc      = sfc_pkg::SEED_RESET;
  logic [15:0] sector_stamp = 16'h0000;

  word_due_t   sector_words_due [$];
  word_due_t   due;

  int n_errors  = 0;
  int n_bytes   = 0;
  int n_words   = 0;
  int n_sectors = 0;
  int n_writes  = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  int pop_phase = 0;
  pop_mode_e pop_mode = POP_ALWAYS;

  sector_framer_crc16 #(.SECTOR_BYTES(SECTOR_BYTES)) dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full),
    .data_byte(data_byte), .second_count(second_count), .end_of_record(end_of_record),
    .empty(empty), .pop(pop),
    .sector_word(sector_word), .word_index(word_index), .last_word(last_word),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  // --------------------------------------------------------------------------
  // Sector arithmetic
  // --------------------------------------------------------------------------

  // MSb-first CRC-16, one data bit per shift
  function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = acc;
    for (int k = 7; k >= 0; k--) begin
      fb = r[15] ^ b[k];
      r  = {r[14:0], 1'b0};
      if (fb) r = r ^ sfc_pkg::CRC_POLY;
    end
    return r;
  endfunction

  // Byte at a given sector offset; every 16-bit field is little-endian
  function automatic logic [7:0] frame_byte(input int pos);
    if (pos >= SECTOR_BYTES)     return 8'h00;
    if (pos == 0)                return cfg_header[7:0];
    if (pos == 1)                return cfg_header[15:8];
    if (pos == 2)                return sector_stamp[7:0];
    if (pos == 3)                return sector_stamp[15:8];
    if (pos == SECTOR_BYTES - 4) return crc_acc[7:0];
    if (pos == SECTOR_BYTES - 3) return crc_acc[15:8];
    if (pos == SECTOR_BYTES - 2) return cfg_footer[7:0];
    if (pos == SECTOR_BYTES - 1) return cfg_footer[15:8];
    if (pos - 4 < PAYLOAD_BYTES) return payload_copy[pos - 4];
    return 8'h00;
  endfunction

  // Take one accepted byte. A byte that meets a full payload first closes the
  // sector: queue its words, then reseed and open the next payload with it.
  function automatic void take_byte(input logic [7:0] b, input logic [15:0] secs);
    word_due_t nxt;
    int        n_out;
    if (bytes_filled >= PAYLOAD_BYTES) begin
      n_out = (SECTOR_BYTES + 7) / 8;
      if (n_out > sfc_pkg::MAX_WORDS) n_out = sfc_pkg::MAX_WORDS;
      for (int w = 0; w < n_out; w++) begin
        for (int k = 0; k < 8; k++) nxt.word[8*k +: 8] = frame_byte(8*w + k);
        nxt.idx  = 6'(w);
        nxt.last = (w + 1 == n_out);
        sector_words_due.push_back(nxt);
      end
      bytes_filled = 0;
      crc_acc      = cfg_seed;
    end
    if (bytes_filled == 0) sector_stamp = secs;
    payload_copy[bytes_filled] = b;
    crc_acc = crc16_step(crc_acc, b);
    bytes_filled++;
  endfunction

  function automatic logic [15:0] reg_value(input logic [sfc_pkg::ADDR_BITS-1:0] addr);
    case (addr)
      sfc_pkg::ADDR_HEADER: return cfg_header;
      sfc_pkg::ADDR_FOOTER: return cfg_footer;
      sfc_pkg::ADDR_SEED:   return cfg_seed;
      default:              return 16'h0000;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Byte intake
  // --------------------------------------------------------------------------

  // Hold push until the framer takes the byte; full is high while it drains
  task automatic send_byte(input logic [7:0] b, input logic [15:0] secs, input logic eor);
    push          <= 1'b1;
    data_byte     <= b;
    second_count  <= secs;
    end_of_record <= eor;
    @(posedge clk);
    while (full) @(posedge clk);
    take_byte(b, secs);
    n_bytes++;
  endtask

  // Bursts of random length, then a short or occasionally long gap;
  // some bursts run straight into the next with no gap at all
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 48);
    if ($urandom_range(0, 3) == 0) return;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 30) : $urandom_range(1, 4);
    push <= 1'b0;
    repeat (gap) @(posedge clk);
  endtask

  task automatic send_bytes(input int count, input bit zero_fill);
    for (int i = 0; i < count; i++) begin
      send_byte(zero_fill ? 8'h00 : 8'($urandom), 16'($urandom), 1'($urandom_range(0, 1)));
      pace_sender();
    end
  endtask

  // Top the payload up, then push the byte that closes it and opens the next
  task automatic finish_sector(input bit zero_fill, input logic [7:0] opener,
                               input logic [15:0] secs);
    send_bytes(PAYLOAD_BYTES - bytes_filled, zero_fill);
    send_byte(opener, secs, 1'($urandom_range(0, 1)));
    n_sectors++;
  endtask

  // Drop push, wait for every queued word, then let the emitter settle
  task automatic wait_sector_drained();
    push <= 1'b0;
    while (sector_words_due.size() != 0) @(posedge clk);
    repeat (DRAIN_GUARD) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Register port
  // --------------------------------------------------------------------------

  task automatic apb_access(input logic [sfc_pkg::ADDR_BITS-1:0] addr, input logic wr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_reg(input logic [sfc_pkg::ADDR_BITS-1:0] addr);
    logic [31:0] rd;
    apb_access(addr, 1'b0, 32'h0, rd);
    if (rd[15:0] !== reg_value(addr)) begin
      $error("prdata @%h: expected %h, got %h", addr, reg_value(addr), rd[15:0]);
      n_errors++;
    end
  endtask

  // Upper write-data bits carry noise; only the low 16 belong to the register
  task automatic write_reg(input logic [sfc_pkg::ADDR_BITS-1:0] addr, input logic [15:0] val);
    logic [31:0] rd;
    apb_access(addr, 1'b1, {16'($urandom), val}, rd);
    case (addr)
      sfc_pkg::ADDR_HEADER: cfg_header = val;
      sfc_pkg::ADDR_FOOTER: cfg_footer = val;
      sfc_pkg::ADDR_SEED:   cfg_seed   = val;
      default: ;
    endcase
    n_writes++;
    check_reg(addr);
  endtask

  function automatic logic [15:0] pick_reg_value();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  task automatic test_register_reset();
    check_reg(sfc_pkg::ADDR_HEADER);
    check_reg(sfc_pkg::ADDR_FOOTER);
    check_reg(sfc_pkg::ADDR_SEED);
  endtask

  // Field extremes at the head of the first payload; none of these bytes
  // closes a sector, so no word may come out. The first one stamps 0xFFFF.
  task automatic test_field_extremes();
    send_byte(8'hFF, 16'hFFFF, 1'b1);
    send_byte(8'h00, 16'h0000, 1'b0);
    for (int k = 0; k < 16; k++) begin
      send_byte((k < 8) ? 8'(1 << k) : ~8'(1 << (k - 8)), 16'(1 << k), 1'(k));
      pace_sender();
    end
  endtask

  // Change seed and markers partway through the first payload: the markers
  // apply to this sector, the seed only to the next. The tail of the payload
  // is all zeros, and the closing byte opens the next payload.
  task automatic test_mid_payload_writes();
    send_bytes(150, 1'b0);
    wait_sector_drained();
    write_reg(sfc_pkg::ADDR_SEED, 16'h0000);
    write_reg(sfc_pkg::ADDR_HEADER, 16'h0000);
    write_reg(sfc_pkg::ADDR_FOOTER, 16'hFFFF);
    finish_sector(1'b1, 8'($urandom), 16'($urandom));
    wait_sector_drained();
  endtask

  // Random settings, then intake into the fresh payload; nothing may come out
  task automatic test_next_payload();
    write_reg(sfc_pkg::ADDR_HEADER, pick_reg_value());
    write_reg(sfc_pkg::ADDR_FOOTER, pick_reg_value());
    write_reg(sfc_pkg::ADDR_SEED, pick_reg_value());
    send_bytes(20, 1'b0);
    wait_sector_drained();
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_register_reset();
    test_field_extremes();
    test_mid_payload_writes();
    test_next_payload();

    // wait_sector_drained above has already emptied the queue and held off
    // long enough for any stray word to show up at the checker
    $display("Framed %0d bytes into %0d closed sectors; %0d sector words checked, %0d writes.",
             n_bytes, n_sectors, n_words, n_writes);
    $display("Covered reset registers, field extremes, marker and seed writes mid-payload,");
    $display("a closed sector with a zero tail and intake into the following payload.");
    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Word checker and receiver stalls
  // --------------------------------------------------------------------------
  // Pop follows a mode that is redrawn at random as the run goes on: always ready,
  // coin flip, a fixed repeating stall pattern, or long stalls.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        n_words++;
        if (sector_words_due.size() == 0) begin
          $error("sector_word: no word expected, got %h (index %0d)", sector_word, word_index);
          n_errors++;
        end else begin
          due = sector_words_due.pop_front();
          if (sector_word !== due.word) begin
            $error("sector_word: expected %h, got %h", due.word, sector_word);
            n_errors++;
          end
          if (word_index !== due.idx) begin
            $error("word_index: expected %0d, got %0d", due.idx, word_index);
            n_errors++;
          end
          if (last_word !== due.last) begin
            $error("last_word: expected %b, got %b", due.last, last_word);
            n_errors++;
          end
        end
      end
      pop_phase <= pop_phase + 1;
      if (pop_phase % 211 == 210) pop_mode <= pop_mode_e'($urandom_range(0, 3));
      case (pop_mode)
        POP_ALWAYS:  pop <= 1'b1;
        POP_COIN:    pop <= 1'($urandom_range(0, 1));
        POP_PATTERN: pop <= (pop_phase % 7) >= 3;
        default:     pop <= (pop_phase % 40) >= 25;
      endcase
    end
  end

  // Watchdog: end the run if no word moves on either side for too long
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Timed out with %0d sector words outstanding.", sector_words_due.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

endmodule

[sim.f]
src/sfc_pkg.sv
src/sfc_ram.sv
src/sfc_job_fifo.sv
src/sfc_front.sv
src/sfc_back.sv
src/sector_framer_crc16.sv
tb/sv/sector_framer_crc16_tb.sv
